// ----- hdl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table search package
// Item types, opcodes and field widths shared by the search block files.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int KEY_WIDTH   = 32;
   localparam int INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                        opcode;
      logic [INDEX_WIDTH-1:0]      entry_index;
      logic signed [KEY_WIDTH-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] position;
   } rsp_type;

endpackage

// ----- hdl/sts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sts_engine.sv -----
// ----------------------------------------------------------------------------
// Search engine
// Bisects the table range, one memory read and one compare per probe.
// ----------------------------------------------------------------------------
module sts_engine
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_WIDTH-1:0]           key,
   input  logic [$clog2(TABLE_DEPTH):0]   count,
   output logic                           busy,
   output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   input  logic [KEY_WIDTH-1:0]           rd_data,
   output logic                           done_valid,
   output rsp_type                        done_result,
   input  logic                           done_take
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PROBE  = 2'd1;
   localparam logic [1:0] ST_CHECK  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        low_ff, low_in;
   logic [AW-1:0]        high_ff, high_in;
   logic [AW-1:0]        probe_ff, probe_in;
   logic                 last_ff, last_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   rsp_type              result_ff, result_in;

   logic [AW-1:0] mid;
   logic [CW-1:0] count_less;
   logic          hit;
   logic          above;

   // The midpoint rounds down and equals low once the range has closed.
   assign mid        = low_ff + ((high_ff - low_ff) >> 1);
   assign count_less = count - CW'(1);
   assign hit        = (rd_data == key_ff);
   assign above      = ($signed(rd_data) > $signed(key_ff));

   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      probe_in  = probe_ff;
      last_in   = last_ff;
      key_in    = key_ff;
      result_in = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = key;
               if (count == '0) begin
                  result_in = '0;
                  state_in  = ST_FINISH;
               end else begin
                  low_in   = '0;
                  high_in  = count_less[AW-1:0];
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            probe_in = mid;
            last_in  = (low_ff == high_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit || last_ff) begin
               result_in.found    = hit;
               result_in.position = INDEX_WIDTH'(probe_ff);
               state_in           = ST_FINISH;
            end else begin
               if (above) begin
                  high_in = probe_ff;
               end else begin
                  low_in = probe_ff + AW'(1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      probe_ff  <= probe_in;
      last_ff   <= last_in;
      key_ff    <= key_in;
      result_ff <= result_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rd_addr     = mid;
   assign done_valid  = (state_ff == ST_FINISH);
   assign done_result = result_ff;

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search
// Table of signed words loaded by write items and searched by key.
// ----------------------------------------------------------------------------
// A write item stores one table word and gives no result. A search item
// bisects entries 0 to entry_count-1 (clamped to the table depth) and
// answers with a found flag and a position. Each probe is a synchronous
// table read followed by a compare; a search of an empty table makes no
// probe and goes straight to its result. Probes run one after another, as
// the table memory has a single read port. One item is worked on at a time;
// a finished result sits in an output register so the next item is taken
// while it waits. Table entries hold nothing until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [COUNT_WIDTH-1:0] csr_write_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;

   logic [COUNT_WIDTH-1:0] entry_count_ff;
   logic [CW-1:0]          count_clamped;
   logic                   req_take;
   logic                   search_start;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [KEY_WIDTH-1:0]   ram_rd_data;
   logic                   engine_busy;
   logic                   done_valid;
   rsp_type                done_result;
   logic                   done_take;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   assign req_stall    = engine_busy;
   assign req_take     = req_valid && !req_stall;
   assign search_start = req_take && (req_data.opcode == OP_SEARCH);
   assign ram_wr_en    = req_take && (req_data.opcode == OP_WRITE) &&
                         (32'(req_data.entry_index) < 32'(TABLE_DEPTH));

   assign count_clamped = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ?
                          CW'(TABLE_DEPTH) : CW'(entry_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_enable) begin
         entry_count_ff <= csr_write_data;
      end
   end

   sts_ram #(
      .WIDTH(KEY_WIDTH),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(AW'(req_data.entry_index)),
      .wr_data(req_data.key_value),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   sts_engine #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (search_start),
      .key        (req_data.key_value),
      .count      (count_clamped),
      .busy       (engine_busy),
      .rd_addr    (ram_rd_addr),
      .rd_data    (ram_rd_data),
      .done_valid (done_valid),
      .done_result(done_result),
      .done_take  (done_take)
   );

   // The output register frees up in the same cycle its item is taken.
   assign done_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && done_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done_valid && done_take) begin
         rsp_data_ff <= done_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_write_during_search: assert property (@(posedge clock) disable iff (reset)
      engine_busy |-> !ram_wr_en)
      else $error("table written while a search is running");

   a_search_starts_engine: assert property (@(posedge clock) disable iff (reset)
      search_start |=> engine_busy)
      else $error("accepted search did not start the engine");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      done_valid |-> engine_busy)
      else $error("search result offered by an idle engine");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Searches the empty table, loads it with non-decreasing signed words, then
// searches under several entry counts and idling patterns. A local predictor
// replays each bisection; every result is checked field by field as it arrives.
// ----------------------------------------------------------------------------
module tb;
   import sts_pkg::*;

   localparam int TABLE_WORDS    = 1024;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [COUNT_WIDTH-1:0] csr_write_data = '0;

   // Local copy of the table and the entry count, kept in step with their writes.
   logic signed [KEY_WIDTH-1:0] word_store [TABLE_WORDS];
   logic [COUNT_WIDTH-1:0]      active_count = '0;
   rsp_type                     expected_results [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  holdoff_pending = 1'b0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;

   sorted_table_binary_search #(
      .TABLE_DEPTH(TABLE_WORDS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type predict_search(logic signed [KEY_WIDTH-1:0] key);
      rsp_type     answer;
      int unsigned span;
      int unsigned lo;
      int unsigned hi;
      int unsigned probe;
      answer = '0;
      span = (active_count > TABLE_WORDS) ? TABLE_WORDS : active_count;
      if (span == 0) begin
         return answer;
      end
      lo = 0;
      hi = span - 1;
      while (lo != hi) begin
         probe = lo + (hi - lo) / 2;
         if (word_store[probe] == key) begin
            answer.found = 1'b1;
            answer.position = INDEX_WIDTH'(probe);
            return answer;
         end
         if (word_store[probe] > key) begin
            hi = probe;
         end else begin
            lo = probe + 1;
         end
      end
      answer.found = (word_store[lo] == key);
      answer.position = INDEX_WIDTH'(lo);
      return answer;
   endfunction

   // Half the keys are present; the rest lie beside a present word, at an extreme, or are random.
   function automatic logic signed [KEY_WIDTH-1:0] pick_key(int unsigned span);
      logic signed [KEY_WIDTH-1:0] hit;
      hit = word_store[$urandom_range(span - 1)];
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return hit;
         5: return hit + 1;
         6: return hit - 1;
         7: return $urandom_range(1) ? KEY_MAX : KEY_MIN;
         default: return $urandom();
      endcase
   endfunction

   task automatic set_idling(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   task automatic send_item(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (item.opcode == OP_WRITE) begin
         word_store[item.entry_index] = item.key_value;
      end else begin
         expected_results.push_back(predict_search(item.key_value));
      end
   endtask

   task automatic send_write(int unsigned index, logic signed [KEY_WIDTH-1:0] value);
      req_type item;
      item.opcode = OP_WRITE;
      item.entry_index = INDEX_WIDTH'(index);
      item.key_value = value;
      send_item(item);
   endtask

   task automatic send_search(logic signed [KEY_WIDTH-1:0] key);
      req_type item;
      item.opcode = OP_SEARCH;
      item.entry_index = INDEX_WIDTH'($urandom());
      item.key_value = key;
      send_item(item);
   endtask

   // A write item leaves no result behind, so a SETTLE_CYCLES wait after the queue empties covers it.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(int unsigned value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= COUNT_WIDTH'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = COUNT_WIDTH'(value);
   endtask

   task automatic test_empty_table();
      set_idling(0, 0);
      send_search(KEY_MIN);
      send_search(KEY_MAX);
      send_search(0);
      send_search(-1);
   endtask

   task automatic test_load_table();
      longint level;
      set_idling(0, 0);
      level = -64'sd2147483648 + longint'($urandom_range(100000, 1000));
      for (int i = 0; i < TABLE_WORDS; i++) begin
         if (i == TABLE_WORDS - 1) begin
            level = 64'sd2147483647;
         end
         send_write(i, level[KEY_WIDTH-1:0]);
         // Occasional equal neighbors give duplicate entries.
         if ($urandom_range(15) != 0) begin
            level += longint'($urandom_range(8000000));
         end
         if (level > 64'sd2147483647) begin
            level = 64'sd2147483647;
         end
      end
   endtask

   task automatic test_directed_search();
      set_idling(0, 0);
      write_entry_count(TABLE_WORDS);
      send_search(KEY_MIN);
      send_search(KEY_MAX);
      send_search(word_store[0]);
      send_search(word_store[511]);
      send_search(word_store[512] + 1);
      send_search(word_store[TABLE_WORDS - 1]);
      send_search(0);
      send_search(-1);
      write_entry_count(1);
      send_search(word_store[0]);
      send_search(KEY_MAX);
      write_entry_count(2);
      send_search(word_store[1]);
      send_search(word_store[0] + 1);
      write_entry_count(3);
      send_search(word_store[2]);
      // Key above every entry in use reports the last index in use.
      write_entry_count(500);
      send_search(KEY_MAX);
      write_entry_count(0);
      send_search(word_store[0]);
      // Counts past the table depth are clamped to it.
      write_entry_count(TABLE_WORDS + 1);
      send_search(word_store[TABLE_WORDS - 1]);
      write_entry_count(2047);
      send_search(word_store[700]);
      send_search(KEY_MIN);
   endtask

   task automatic test_random_search(int sender_pct, int receiver_pct);
      int unsigned span;
      set_idling(sender_pct, receiver_pct);
      for (int round = 0; round < 3; round++) begin
         case ($urandom_range(5))
            0: span = 1;
            1: span = 2;
            2: span = 3;
            3: span = $urandom_range(64, 4);
            4: span = $urandom_range(TABLE_WORDS - 1, 65);
            default: span = TABLE_WORDS;
         endcase
         write_entry_count(span);
         repeat (40) send_search(pick_key(span));
      end
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      write_entry_count(TABLE_WORDS);
      holdoff_pending = 1'b1;
      repeat (40) send_search(pick_key(TABLE_WORDS));
   endtask

   task automatic test_unsorted_table();
      int unsigned span;
      set_idling(38, 38);
      span = $urandom_range(200, 8);
      write_entry_count(span);
      repeat (60) begin
         send_write($urandom_range(span - 1), $urandom());
         send_search(pick_key(span));
      end
      write_entry_count(TABLE_WORDS);
      repeat (20) send_search(pick_key(TABLE_WORDS));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_load_table();
      test_directed_search();
      test_random_search(0, 0);
      test_random_search(70, 0);
      test_random_search(0, 70);
      test_random_search(38, 38);
      test_backpressure();
      test_unsorted_table();
      drain_results();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Result receiver; a requested hold-off keeps stall high for a long stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: found %0d, position %0d",
                   rsp_data.found, rsp_data.position);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
               mismatch_count++;
            end
            if (rsp_data.position !== want.position) begin
               $error("position: expected %0d, actual %0d",
                      want.position, rsp_data.position);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
